// File: rtl/tbb_pkg.sv
package tbb_pkg;

  // Output rows held in configuration, one per transformed axis.
  localparam int AXES      = 3;
  localparam int COEF_W    = 16;
  localparam int ROW_W     = 64;
  localparam int PROD_W    = 2 * COEF_W;
  // Three products plus the shifted translation, with sign and headroom.
  localparam int SUM_W     = PROD_W + 2;
  localparam int FRAC_BITS = 8;
  localparam int QUOT_W    = SUM_W - FRAC_BITS;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ROW_X = 2'd0,
    CFG_ROW_Y = 2'd1,
    CFG_ROW_Z = 2'd2
  } cfg_idx_t;

  typedef logic signed [COEF_W-1:0] q88_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // One input item: the box corners.
  typedef struct packed {
    q88_t min_x;
    q88_t min_y;
    q88_t min_z;
    q88_t max_x;
    q88_t max_y;
    q88_t max_z;
  } box_t;

  // One result item: the transformed bounds.
  typedef struct packed {
    q88_t out_min_x;
    q88_t out_min_y;
    q88_t out_min_z;
    q88_t out_max_x;
    q88_t out_max_y;
    q88_t out_max_z;
  } bounds_t;

  // Coefficient k of a packed row; the translation is k = 3.
  function automatic q88_t row_coef(input logic [ROW_W-1:0] row, input int unsigned k);
    return q88_t'(row[COEF_W*k +: COEF_W]);
  endfunction

  // Round half up to Q8.8 and saturate to the 16-bit range.
  function automatic q88_t round_sat(input sum_t acc);
    sum_t                     t;
    logic signed [QUOT_W-1:0] q;
    q88_t                     r;
    t = acc + SUM_W'(128);
    q = t[SUM_W-1:FRAC_BITS];
    if (q > QUOT_W'(32767)) begin
      r = 16'sh7fff;
    end else if (q < -QUOT_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = q[COEF_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/tbb_box_if.sv
interface tbb_box_if;
  import tbb_pkg::*;

  logic valid;
  logic ready;
  box_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/tbb_bounds_if.sv
interface tbb_bounds_if;
  import tbb_pkg::*;

  logic    valid;
  logic    ready;
  bounds_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/transform_bounding_box.sv
// Axis-aligned box transform.
//
// Input channel in_ch carries one box per item as its minimum and maximum
// corners in signed Q8.8. Result channel out_ch returns the bounds of the box
// after the affine transform held in the three matrix rows, rounded half up
// and saturated to Q8.8. Every input item yields exactly one result item.
// The rows are written through cfg_we, cfg_idx and cfg_data while no item is
// in flight; a write to an index past the last row is ignored.
//
// There are four register stages: products, per-term minimum and maximum,
// the row sums, then rounding into the output register. An accepted item
// passes through the product, extreme, sum and output registers in order
// before out_ch.valid rises. Throughput is one item per cycle while the
// receiver is ready. The corner search needs no loop because each row is a
// sum of independent terms, so its extremes are sums of each term's extremes.
//
// Reset clears the matrix rows and all stage valid bits. When the receiver
// stalls, each stage holds its item and empty stages keep filling, so up to
// four items wait in the pipeline before in_ch.ready drops.
module transform_bounding_box (
  input  logic                       clk,
  input  logic                       rst_n,
  tbb_box_if.sink                    in_ch,
  tbb_bounds_if.source               out_ch,
  input  logic                       cfg_we,
  input  tbb_pkg::cfg_idx_t          cfg_idx,
  input  logic [tbb_pkg::ROW_W-1:0]  cfg_data
);
  import tbb_pkg::*;

  logic [ROW_W-1:0] row_r [AXES];

  logic  v1_r, v2_r, v3_r, v4_r;
  logic  en1, en2, en3, en4;

  prod_t   lo_nxt [AXES][AXES];
  prod_t   hi_nxt [AXES][AXES];
  prod_t   lo_r   [AXES][AXES];
  prod_t   hi_r   [AXES][AXES];
  prod_t   mn_nxt [AXES][AXES];
  prod_t   mx_nxt [AXES][AXES];
  prod_t   mn_r   [AXES][AXES];
  prod_t   mx_r   [AXES][AXES];
  sum_t    smn_nxt [AXES];
  sum_t    smx_nxt [AXES];
  sum_t    smn_r   [AXES];
  sum_t    smx_r   [AXES];
  bounds_t out_nxt;
  bounds_t out_r;
  q88_t    lo_in [AXES];
  q88_t    hi_in [AXES];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXES; a++) begin
        row_r[a] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ROW_X: row_r[0] <= cfg_data;
        CFG_ROW_Y: row_r[1] <= cfg_data;
        CFG_ROW_Z: row_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or the stage after it moves on.
  assign en4 = !v4_r || out_ch.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // Stage 1: every coefficient against both candidate coordinates.
  always_comb begin
    lo_in[0] = in_ch.data.min_x;
    lo_in[1] = in_ch.data.min_y;
    lo_in[2] = in_ch.data.min_z;
    hi_in[0] = in_ch.data.max_x;
    hi_in[1] = in_ch.data.max_y;
    hi_in[2] = in_ch.data.max_z;
    for (int a = 0; a < AXES; a++) begin
      for (int k = 0; k < AXES; k++) begin
        lo_nxt[a][k] = row_coef(row_r[a], k) * lo_in[k];
        hi_nxt[a][k] = row_coef(row_r[a], k) * hi_in[k];
      end
    end
  end

  // Stage 2: the smaller and larger product of each term.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      for (int k = 0; k < AXES; k++) begin
        if (lo_r[a][k] < hi_r[a][k]) begin
          mn_nxt[a][k] = lo_r[a][k];
          mx_nxt[a][k] = hi_r[a][k];
        end else begin
          mn_nxt[a][k] = hi_r[a][k];
          mx_nxt[a][k] = lo_r[a][k];
        end
      end
    end
  end

  // Stage 3: row sums of the term extremes plus the translation, in Q18.16.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      smn_nxt[a] = SUM_W'(mn_r[a][0]) + SUM_W'(mn_r[a][1]) + SUM_W'(mn_r[a][2])
                 + (SUM_W'(row_coef(row_r[a], 3)) <<< FRAC_BITS);
      smx_nxt[a] = SUM_W'(mx_r[a][0]) + SUM_W'(mx_r[a][1]) + SUM_W'(mx_r[a][2])
                 + (SUM_W'(row_coef(row_r[a], 3)) <<< FRAC_BITS);
    end
  end

  // Stage 4: rounding and saturation into the output register.
  always_comb begin
    out_nxt.out_min_x = round_sat(smn_r[0]);
    out_nxt.out_min_y = round_sat(smn_r[1]);
    out_nxt.out_min_z = round_sat(smn_r[2]);
    out_nxt.out_max_x = round_sat(smx_r[0]);
    out_nxt.out_max_y = round_sat(smx_r[1]);
    out_nxt.out_max_z = round_sat(smx_r[2]);
  end

  // Payload registers follow their stage enables.
  always_ff @(posedge clk) begin
    if (en1) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    if (en2) begin
      mn_r <= mn_nxt;
      mx_r <= mx_nxt;
    end
    if (en3) begin
      smn_r <= smn_nxt;
      smx_r <= smx_nxt;
    end
    if (en4) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid = v4_r;
  assign out_ch.data  = out_r;

endmodule

// File: rtl/tbb_checker.sv
module tbb_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input tbb_pkg::bounds_t out_data
);
  import tbb_pkg::*;

  logic [2:0] pending_r;
  logic [2:0] pending_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Items accepted but not yet delivered.
  always_comb begin
    pending_nxt = pending_r + 3'(in_acc) - 3'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // The pipeline holds at most four items.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 3'd4)
    else $error("more items in flight than pipeline stages");

  // No result appears without an item behind it.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 3'd0)
    else $error("result with no item in flight");

  // A free output means every stage can move, so input is open.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input blocked while output drains");

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind transform_bounding_box tbb_checker u_tbb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
